/* rtl/assert_macros.svh */
// Assertion macros shared by the character LCD sequencer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define LCDNS_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Antecedent in a cycle requires the consequent in the same cycle.
`define LCDNS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/lcdns_pkg.sv */
// Types, opcodes and the init step table for the character LCD sequencer.
// Depends on nothing; used by every module of the block.
package lcdns_pkg;

	// Request codes on the command input.
	typedef enum logic [2:0] {
		CMD_INIT   = 3'd0,
		CMD_WRCMD  = 3'd1,
		CMD_WRDATA = 3'd2,
		CMD_CLEAR  = 3'd3,
		CMD_HOME   = 3'd4,
		CMD_CURSOR = 3'd5,
		CMD_GLYPH  = 3'd6,
		CMD_NONE   = 3'd7
	} cmd_t;

	// Wait classes handed to the downstream timer.
	localparam logic [3:0] WC_NONE  = 4'd0;
	localparam logic [3:0] WC_DATA  = 4'd1;
	localparam logic [3:0] WC_CMD   = 4'd2;
	localparam logic [3:0] WC_CLEAR = 4'd3;
	localparam logic [3:0] WC_HOME  = 4'd4;
	localparam logic [3:0] WC_BOOT  = 4'd5;
	localparam logic [3:0] WC_SRST1 = 4'd6;
	localparam logic [3:0] WC_SRST2 = 4'd7;
	localparam logic [3:0] WC_SRST3 = 4'd8;
	localparam logic [3:0] WC_MODE  = 4'd9;

	// Controller instruction opcodes.
	localparam logic [7:0] OP_CLEAR   = 8'h01;
	localparam logic [7:0] OP_HOME    = 8'h02;
	localparam logic [7:0] OP_ENTRY   = 8'h06;
	localparam logic [7:0] OP_DISPLAY = 8'h0C;
	localparam logic [7:0] OP_FUNC    = 8'h28;
	localparam logic [7:0] OP_SET_CG  = 8'h40;
	localparam logic [7:0] OP_SET_DD  = 8'h80;
	localparam logic [3:0] NIB_SRST   = 4'h3;
	localparam logic [3:0] NIB_4BIT   = 4'h2;
	localparam logic [7:0] HI_MASK    = 8'hF0;
	localparam logic [7:0] LO_MASK    = 8'h0F;

	// Register select values.
	localparam logic RS_INSTR = 1'b0;
	localparam logic RS_DATA  = 1'b1;

	// Reset values of the row start addresses.
	localparam logic [6:0] LINE0_RST = 7'd0;
	localparam logic [6:0] LINE1_RST = 7'd64;
	localparam logic [6:0] LINE2_RST = 7'd16;
	localparam logic [6:0] LINE3_RST = 7'd80;
	localparam int LINE_COUNT = 4;

	// Request queue geometry.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Number of bus steps in the init sequence.
	localparam int INIT_STEPS = 13;
	localparam logic [3:0] INIT_LAST = 4'(INIT_STEPS - 1);

	// One classified request waiting for the back end.
	typedef struct packed {
		logic       is_init;
		logic       rs;
		logic [7:0] byte_val;
		logic [3:0] wc;
	} entry_t;

	// One bus step as seen on the output.
	typedef struct packed {
		logic       rs;
		logic [3:0] nibble;
		logic       strobe;
		logic [3:0] wc;
		logic       last;
	} step_t;

	function automatic step_t mk_step(logic rs, logic [3:0] nib, logic strobe,
			logic [3:0] wc, logic last);
		step_t s;
		s.rs     = rs;
		s.nibble = nib;
		s.strobe = strobe;
		s.wc     = wc;
		s.last   = last;
		return s;
	endfunction

	// Power-up sequence: boot wait, three soft resets, 4-bit switch, then
	// function set, display on, entry mode and clear, each as two nibbles.
	function automatic step_t init_step(logic [3:0] idx);
		step_t s;
		case (idx)
			4'd0:    s = mk_step(RS_INSTR, 4'h0, 1'b0, WC_BOOT, 1'b0);
			4'd1:    s = mk_step(RS_INSTR, NIB_SRST, 1'b1, WC_SRST1, 1'b0);
			4'd2:    s = mk_step(RS_INSTR, NIB_SRST, 1'b1, WC_SRST2, 1'b0);
			4'd3:    s = mk_step(RS_INSTR, NIB_SRST, 1'b1, WC_SRST3, 1'b0);
			4'd4:    s = mk_step(RS_INSTR, NIB_4BIT, 1'b1, WC_MODE, 1'b0);
			4'd5:    s = mk_step(RS_INSTR, OP_FUNC[7:4], 1'b1, WC_NONE, 1'b0);
			4'd6:    s = mk_step(RS_INSTR, OP_FUNC[3:0], 1'b1, WC_CMD, 1'b0);
			4'd7:    s = mk_step(RS_INSTR, OP_DISPLAY[7:4], 1'b1, WC_NONE, 1'b0);
			4'd8:    s = mk_step(RS_INSTR, OP_DISPLAY[3:0], 1'b1, WC_CMD, 1'b0);
			4'd9:    s = mk_step(RS_INSTR, OP_ENTRY[7:4], 1'b1, WC_NONE, 1'b0);
			4'd10:   s = mk_step(RS_INSTR, OP_ENTRY[3:0], 1'b1, WC_CMD, 1'b0);
			4'd11:   s = mk_step(RS_INSTR, OP_CLEAR[7:4], 1'b1, WC_NONE, 1'b0);
			4'd12:   s = mk_step(RS_INSTR, OP_CLEAR[3:0], 1'b1, WC_CLEAR, 1'b1);
			default: s = mk_step(RS_INSTR, 4'h0, 1'b0, WC_NONE, 1'b1);
		endcase
		return s;
	endfunction

endpackage

/* rtl/char_lcd_nibble_sequencer.sv */
// Top level of the character LCD nibble sequencer.
// Depends on lcdns_pkg, lcdns_front, lcdns_queue and lcdns_back.
//
// Each request becomes a burst of 4-bit bus steps for an HD44780-style
// display, one step per cycle while the output is taken. A byte request
// (write command, write data, clear, home, set cursor, set glyph address)
// produces two steps, high nibble first; init produces thirteen steps. The
// step generator in the back end sets the rate: the front end classifies one
// request per cycle while its four-entry queue is not full, so new requests
// are taken while earlier ones are still being expanded. A set cursor request
// with a row out of range, and request code 7, are taken and produce nothing.
// The configuration port is always ready and writes the row start addresses.
module char_lcd_nibble_sequencer #(
	parameter int ROW_COUNT = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// Configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data,
	// Request channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] command,
	input  logic [7:0] value,
	input  logic [7:0] col,
	input  logic [7:0] row,
	input  logic [2:0] glyph,
	// Step channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic       reg_select,
	output logic [3:0] nibble,
	output logic       strobe_res,
	output logic [3:0] wait_class,
	output logic       last
);

	logic              push;
	lcdns_pkg::entry_t push_entry;
	logic              pop;
	logic              full;
	logic              empty;
	lcdns_pkg::entry_t head;
	lcdns_pkg::step_t  out_step;

	assign cfg_ready = 1'b1;
	assign in_ready  = !full;

	// Request classification and row base registers.
	lcdns_front #(
		.ROW_COUNT(ROW_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (in_valid && !full),
		.command   (command),
		.value     (value),
		.col       (col),
		.row       (row),
		.glyph     (glyph),
		.push      (push),
		.push_entry(push_entry)
	);

	// Queue decoupling the two ends.
	lcdns_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.head      (head)
	);

	// Step generation and output register.
	lcdns_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_step (out_step)
	);

	assign reg_select = out_step.rs;
	assign nibble     = out_step.nibble;
	assign strobe_res = out_step.strobe;
	assign wait_class = out_step.wc;
	assign last       = out_step.last;

endmodule

/* rtl/lcdns_front.sv */
// Front end: takes requests, holds the row base registers and classifies
// each request into a queue entry. Depends on lcdns_pkg.
module lcdns_front #(
	parameter int ROW_COUNT = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_index,
	input  logic [6:0]          cfg_data,
	input  logic                take,
	input  logic [2:0]          command,
	input  logic [7:0]          value,
	input  logic [7:0]          col,
	input  logic [7:0]          row,
	input  logic [2:0]          glyph,
	output logic                push,
	output lcdns_pkg::entry_t   push_entry
);

	logic [6:0] base_q [lcdns_pkg::LINE_COUNT];
	logic       row_ok;
	logic       emit;
	logic [7:0] cursor_addr;

	// Row start address registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q[0] <= lcdns_pkg::LINE0_RST;
			base_q[1] <= lcdns_pkg::LINE1_RST;
			base_q[2] <= lcdns_pkg::LINE2_RST;
			base_q[3] <= lcdns_pkg::LINE3_RST;
		end else if (cfg_valid && (cfg_index < 3'(lcdns_pkg::LINE_COUNT))) begin
			base_q[cfg_index[1:0]] <= cfg_data;
		end
	end

	// Cursor address wraps at 256.
	assign row_ok      = (row < 8'(ROW_COUNT)) && (row < 8'(lcdns_pkg::LINE_COUNT));
	assign cursor_addr = lcdns_pkg::OP_SET_DD + {1'b0, base_q[row[1:0]]} + col;

	// Classify the request into byte, init or nothing.
	always_comb begin
		emit                = 1'b1;
		push_entry.is_init  = 1'b0;
		push_entry.rs       = lcdns_pkg::RS_INSTR;
		push_entry.byte_val = value;
		push_entry.wc       = lcdns_pkg::WC_CMD;
		case (lcdns_pkg::cmd_t'(command))
			lcdns_pkg::CMD_INIT: begin
				push_entry.is_init = 1'b1;
			end
			lcdns_pkg::CMD_WRCMD: begin
				push_entry.byte_val = value;
			end
			lcdns_pkg::CMD_WRDATA: begin
				push_entry.rs = lcdns_pkg::RS_DATA;
				push_entry.wc = lcdns_pkg::WC_DATA;
			end
			lcdns_pkg::CMD_CLEAR: begin
				push_entry.byte_val = lcdns_pkg::OP_CLEAR;
				push_entry.wc       = lcdns_pkg::WC_CLEAR;
			end
			lcdns_pkg::CMD_HOME: begin
				push_entry.byte_val = lcdns_pkg::OP_HOME;
				push_entry.wc       = lcdns_pkg::WC_HOME;
			end
			lcdns_pkg::CMD_CURSOR: begin
				push_entry.byte_val = cursor_addr;
				emit                = row_ok;
			end
			lcdns_pkg::CMD_GLYPH: begin
				push_entry.byte_val = lcdns_pkg::OP_SET_CG | {2'b00, glyph, 3'b000};
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign push = take && emit;

endmodule

/* rtl/lcdns_queue.sv */
// Short request queue between the front and back ends.
// Depends on lcdns_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcdns_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lcdns_pkg::entry_t push_entry,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output lcdns_pkg::entry_t head
);

	lcdns_pkg::entry_t               mem_q [lcdns_pkg::QUEUE_DEPTH];
	logic [lcdns_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [lcdns_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [lcdns_pkg::QPTR_W:0]      count_q;

	assign full  = (count_q == (lcdns_pkg::QPTR_W+1)'(lcdns_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + (lcdns_pkg::QPTR_W)'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + (lcdns_pkg::QPTR_W)'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (lcdns_pkg::QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (lcdns_pkg::QPTR_W+1)'(1);
			end
		end
	end

	`LCDNS_ASSERT_IMPLIES(a_no_push_full, clk, arst_n, push, !full)
	`LCDNS_ASSERT_IMPLIES(a_no_pop_empty, clk, arst_n, pop, !empty)

endmodule

/* rtl/lcdns_back.sv */
// Back end: expands the queue head into bus steps and holds the output
// register. Depends on lcdns_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcdns_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  lcdns_pkg::entry_t head,
	output logic              pop,
	input  logic              out_ready,
	output logic              out_valid,
	output lcdns_pkg::step_t  out_step
);

	logic [3:0]       step_cnt_q;
	logic             out_valid_q;
	lcdns_pkg::step_t out_step_q;
	lcdns_pkg::step_t cur_step;
	logic             adv;
	logic             fire;

	// Current step of the head request.
	always_comb begin
		if (head.is_init) begin
			cur_step = lcdns_pkg::init_step(step_cnt_q);
		end else if (!step_cnt_q[0]) begin
			cur_step = lcdns_pkg::mk_step(head.rs,
				4'((head.byte_val & lcdns_pkg::HI_MASK) >> 4), 1'b1,
				lcdns_pkg::WC_NONE, 1'b0);
		end else begin
			cur_step = lcdns_pkg::mk_step(head.rs,
				4'(head.byte_val & lcdns_pkg::LO_MASK), 1'b1, head.wc, 1'b1);
		end
	end

	// Output register advances when empty or being taken.
	assign adv  = !out_valid_q || out_ready;
	assign fire = adv && !empty;
	assign pop  = fire && cur_step.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_cnt_q  <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= !empty;
			end
			if (fire) begin
				step_cnt_q <= cur_step.last ? 4'd0 : step_cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_step_q <= cur_step;
		end
	end

	assign out_valid = out_valid_q;
	assign out_step  = out_step_q;

	`LCDNS_ASSERT_ALWAYS(a_cnt_range, clk, arst_n, step_cnt_q <= lcdns_pkg::INIT_LAST)
	`LCDNS_ASSERT_IMPLIES(a_byte_two_steps, clk, arst_n, !empty && !head.is_init,
		step_cnt_q <= 4'd1)

endmodule

/* bench/tb_char_lcd_nibble_sequencer.sv */
`timescale 1ns / 1ps
// Self-checking bench for char_lcd_nibble_sequencer: a directed table and random requests.
// It also writes the row base registers and checks every LCD bus step against its own predictor.
// Depends on lcdns_pkg and the sequencer RTL.
module tb_char_lcd_nibble_sequencer;

	localparam int ROW_COUNT       = 4;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 56;
	localparam int SETTLE_CYCLES   = 40;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int MAX_REPORTS     = 40;
	localparam int INDEX_SPAN      = 8;

	// Where the expected steps of a request come from.
	typedef enum {FROM_MODEL, TYPED_BYTE, TYPED_NONE} source_t;

	typedef struct {
		logic [2:0] cmd;
		logic [7:0] value;
		logic [7:0] col;
		logic [7:0] row;
		logic [2:0] glyph;
		source_t    source;
		logic       rs;
		logic [7:0] octet;
		logic [3:0] wc;
	} request_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [6:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] command;
	logic [7:0] value;
	logic [7:0] col;
	logic [7:0] row;
	logic [2:0] glyph;
	logic       out_valid;
	logic       out_ready;
	logic       reg_select;
	logic [3:0] nibble;
	logic       strobe_res;
	logic [3:0] wait_class;
	logic       last;

	request_t          req_now;
	lcdns_pkg::step_t  pending_steps[$];
	logic [6:0]        row_base[lcdns_pkg::LINE_COUNT];
	int                send_idle_pct;
	int                stall_pct;
	int                mismatches = 0;
	int                cycle_count;

	char_lcd_nibble_sequencer #(.ROW_COUNT(ROW_COUNT)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .command(command), .value(value),
		.col(col), .row(row), .glyph(glyph),
		.out_valid(out_valid), .out_ready(out_ready), .reg_select(reg_select),
		.nibble(nibble), .strobe_res(strobe_res), .wait_class(wait_class), .last(last)
	);

	always #5 clk = ~clk;

	// Step predictor: appends the bus steps that a request produces.
	function automatic void add_step(logic rs, logic [3:0] nib, logic stb, logic [3:0] wc,
			logic fin);
		lcdns_pkg::step_t s;
		s.rs     = rs;
		s.nibble = nib;
		s.strobe = stb;
		s.wc     = wc;
		s.last   = fin;
		pending_steps.push_back(s);
	endfunction

	// A byte goes out high nibble first; only the low nibble carries the wait class.
	function automatic void add_byte(logic rs, logic [7:0] octet, logic [3:0] wc, logic fin);
		add_step(rs, octet[7:4], 1'b1, lcdns_pkg::WC_NONE, 1'b0);
		add_step(rs, octet[3:0], 1'b1, wc, fin);
	endfunction

	function automatic void predict_request(logic [2:0] cmd, logic [7:0] val,
			logic [7:0] column, logic [7:0] line, logic [2:0] gl);
		case (lcdns_pkg::cmd_t'(cmd))
			lcdns_pkg::CMD_INIT: begin
				add_step(lcdns_pkg::RS_INSTR, 4'h0, 1'b0, lcdns_pkg::WC_BOOT, 1'b0);
				add_step(lcdns_pkg::RS_INSTR, lcdns_pkg::NIB_SRST, 1'b1,
					lcdns_pkg::WC_SRST1, 1'b0);
				add_step(lcdns_pkg::RS_INSTR, lcdns_pkg::NIB_SRST, 1'b1,
					lcdns_pkg::WC_SRST2, 1'b0);
				add_step(lcdns_pkg::RS_INSTR, lcdns_pkg::NIB_SRST, 1'b1,
					lcdns_pkg::WC_SRST3, 1'b0);
				add_step(lcdns_pkg::RS_INSTR, lcdns_pkg::NIB_4BIT, 1'b1,
					lcdns_pkg::WC_MODE, 1'b0);
				add_byte(lcdns_pkg::RS_INSTR, lcdns_pkg::OP_FUNC, lcdns_pkg::WC_CMD, 1'b0);
				add_byte(lcdns_pkg::RS_INSTR, lcdns_pkg::OP_DISPLAY, lcdns_pkg::WC_CMD, 1'b0);
				add_byte(lcdns_pkg::RS_INSTR, lcdns_pkg::OP_ENTRY, lcdns_pkg::WC_CMD, 1'b0);
				add_byte(lcdns_pkg::RS_INSTR, lcdns_pkg::OP_CLEAR, lcdns_pkg::WC_CLEAR, 1'b1);
			end
			lcdns_pkg::CMD_WRCMD:
				add_byte(lcdns_pkg::RS_INSTR, val, lcdns_pkg::WC_CMD, 1'b1);
			lcdns_pkg::CMD_WRDATA:
				add_byte(lcdns_pkg::RS_DATA, val, lcdns_pkg::WC_DATA, 1'b1);
			lcdns_pkg::CMD_CLEAR:
				add_byte(lcdns_pkg::RS_INSTR, lcdns_pkg::OP_CLEAR, lcdns_pkg::WC_CLEAR, 1'b1);
			lcdns_pkg::CMD_HOME:
				add_byte(lcdns_pkg::RS_INSTR, lcdns_pkg::OP_HOME, lcdns_pkg::WC_HOME, 1'b1);
			// Rows past the display produce nothing; the address wraps at 256.
			lcdns_pkg::CMD_CURSOR: begin
				if (line < ROW_COUNT && line < lcdns_pkg::LINE_COUNT)
					add_byte(lcdns_pkg::RS_INSTR,
						lcdns_pkg::OP_SET_DD + {1'b0, row_base[line[1:0]]} + column,
						lcdns_pkg::WC_CMD, 1'b1);
			end
			lcdns_pkg::CMD_GLYPH:
				add_byte(lcdns_pkg::RS_INSTR, lcdns_pkg::OP_SET_CG | {2'b00, gl, 3'b000},
					lcdns_pkg::WC_CMD, 1'b1);
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s is %h, expected %h", cycle_count, what, got,
				want);
	endtask

	// Mirror register writes, predict accepted requests and check each step transfer.
	always @(posedge clk) begin : step_monitor
		lcdns_pkg::step_t want;
		if (!arst_n) begin
			row_base[0] = lcdns_pkg::LINE0_RST;
			row_base[1] = lcdns_pkg::LINE1_RST;
			row_base[2] = lcdns_pkg::LINE2_RST;
			row_base[3] = lcdns_pkg::LINE3_RST;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < lcdns_pkg::LINE_COUNT)
				row_base[cfg_index[1:0]] = cfg_data;
			if (in_valid && in_ready) begin
				case (req_now.source)
					TYPED_BYTE: add_byte(req_now.rs, req_now.octet, req_now.wc, 1'b1);
					TYPED_NONE: ;
					default: predict_request(command, value, col, row, glyph);
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_steps.size() == 0) begin
					report_mismatch("step with nothing pending, nibble", 8'(nibble), 8'h00);
				end else begin
					want = pending_steps.pop_front();
					if (reg_select !== want.rs)
						report_mismatch("reg_select", 8'(reg_select), 8'(want.rs));
					if (nibble !== want.nibble)
						report_mismatch("nibble", 8'(nibble), 8'(want.nibble));
					if (strobe_res !== want.strobe)
						report_mismatch("strobe_res", 8'(strobe_res), 8'(want.strobe));
					if (wait_class !== want.wc)
						report_mismatch("wait_class", 8'(wait_class), 8'(want.wc));
					if (last !== want.last)
						report_mismatch("last", 8'(last), 8'(want.last));
				end
			end
		end
	end

	// Receiver back-pressure.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog on the cycle count.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	// Hold the payload until the transfer; lower valid only ahead of a gap.
	task automatic send_request(input request_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		command  <= r.cmd;
		value    <= r.value;
		col      <= r.col;
		row      <= r.row;
		glyph    <= r.glyph;
		req_now  <= r;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [6:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic wait_for_steps();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_steps.size() != 0);
	endtask

	// Requests that produce no steps may still sit in the queue after the last step.
	task automatic wait_settled();
		wait_for_steps();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_line_bases(input int phase);
		logic [6:0] base;
		for (int i = 0; i < lcdns_pkg::LINE_COUNT; i++) begin
			case (phase)
				1:       base = 7'h00;
				2:       base = 7'h7F;
				5:       base = i[0] ? 7'h00 : 7'h7F;
				default: base = 7'($urandom);
			endcase
			write_register(3'(i), base);
		end
		// Indices past the last row must leave the row bases alone.
		if (phase == 4 || phase == 7)
			for (int i = lcdns_pkg::LINE_COUNT; i < INDEX_SPAN; i++)
				write_register(3'(i), 7'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic request_t dir_entry(logic [2:0] cmd, logic [7:0] val, logic [7:0] column,
			logic [7:0] line, logic [2:0] gl, source_t src, logic rs, logic [7:0] octet,
			logic [3:0] wc);
		request_t r;
		r.cmd    = cmd;
		r.value  = val;
		r.col    = column;
		r.row    = line;
		r.glyph  = gl;
		r.source = src;
		r.rs     = rs;
		r.octet  = octet;
		r.wc     = wc;
		return r;
	endfunction

	// Random mix: mostly byte requests and in-range cursor moves, some init and noise.
	function automatic request_t random_request();
		request_t r;
		int pick;
		pick = $urandom_range(99);
		r = dir_entry(lcdns_pkg::CMD_NONE, 8'($urandom), 8'($urandom), 8'($urandom),
			3'($urandom), FROM_MODEL, lcdns_pkg::RS_INSTR, 8'h00, lcdns_pkg::WC_NONE);
		if (pick < 4)
			r.cmd = lcdns_pkg::CMD_INIT;
		else if (pick < 22)
			r.cmd = lcdns_pkg::CMD_WRCMD;
		else if (pick < 42)
			r.cmd = lcdns_pkg::CMD_WRDATA;
		else if (pick < 48)
			r.cmd = lcdns_pkg::CMD_CLEAR;
		else if (pick < 54)
			r.cmd = lcdns_pkg::CMD_HOME;
		else if (pick < 82) begin
			r.cmd = lcdns_pkg::CMD_CURSOR;
			if ($urandom_range(99) < 80)
				r.row = 8'($urandom_range(3));
		end else if (pick < 95)
			r.cmd = lcdns_pkg::CMD_GLYPH;
		return r;
	endfunction

	initial begin
		request_t directed[$];
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		command       = lcdns_pkg::CMD_NONE;
		value         = '0;
		col           = '0;
		row           = '0;
		glyph         = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		req_now       = dir_entry(lcdns_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 3'd0,
			TYPED_NONE, lcdns_pkg::RS_INSTR, 8'h00, lcdns_pkg::WC_NONE);

		// Directed table, run with the row bases at their reset values.
		directed.push_back(dir_entry(lcdns_pkg::CMD_INIT, 8'h00, 8'h00, 8'h00, 3'd0,
			FROM_MODEL, lcdns_pkg::RS_INSTR, 8'h00, lcdns_pkg::WC_NONE));
		directed.push_back(dir_entry(lcdns_pkg::CMD_WRCMD, 8'h00, 8'h00, 8'h00, 3'd0,
			TYPED_BYTE, lcdns_pkg::RS_INSTR, 8'h00, lcdns_pkg::WC_CMD));
		directed.push_back(dir_entry(lcdns_pkg::CMD_WRCMD, 8'hFF, 8'h00, 8'h00, 3'd0,
			TYPED_BYTE, lcdns_pkg::RS_INSTR, 8'hFF, lcdns_pkg::WC_CMD));
		directed.push_back(dir_entry(lcdns_pkg::CMD_WRDATA, 8'h00, 8'h00, 8'h00, 3'd0,
			TYPED_BYTE, lcdns_pkg::RS_DATA, 8'h00, lcdns_pkg::WC_DATA));
		directed.push_back(dir_entry(lcdns_pkg::CMD_WRDATA, 8'hFF, 8'h00, 8'h00, 3'd0,
			TYPED_BYTE, lcdns_pkg::RS_DATA, 8'hFF, lcdns_pkg::WC_DATA));
		directed.push_back(dir_entry(lcdns_pkg::CMD_WRDATA, 8'hA5, 8'hFF, 8'hFF, 3'd7,
			FROM_MODEL, lcdns_pkg::RS_INSTR, 8'h00, lcdns_pkg::WC_NONE));
		directed.push_back(dir_entry(lcdns_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00, 3'd0,
			TYPED_BYTE, lcdns_pkg::RS_INSTR, lcdns_pkg::OP_CLEAR, lcdns_pkg::WC_CLEAR));
		directed.push_back(dir_entry(lcdns_pkg::CMD_HOME, 8'h00, 8'h00, 8'h00, 3'd0,
			TYPED_BYTE, lcdns_pkg::RS_INSTR, lcdns_pkg::OP_HOME, lcdns_pkg::WC_HOME));
		directed.push_back(dir_entry(lcdns_pkg::CMD_CURSOR, 8'h00, 8'h00, 8'h00, 3'd0,
			TYPED_BYTE, lcdns_pkg::RS_INSTR, 8'h80, lcdns_pkg::WC_CMD));
		directed.push_back(dir_entry(lcdns_pkg::CMD_CURSOR, 8'h00, 8'h00, 8'h01, 3'd0,
			TYPED_BYTE, lcdns_pkg::RS_INSTR, 8'hC0, lcdns_pkg::WC_CMD));
		directed.push_back(dir_entry(lcdns_pkg::CMD_CURSOR, 8'h00, 8'h00, 8'h02, 3'd0,
			TYPED_BYTE, lcdns_pkg::RS_INSTR, 8'h90, lcdns_pkg::WC_CMD));
		directed.push_back(dir_entry(lcdns_pkg::CMD_CURSOR, 8'h00, 8'h00, 8'h03, 3'd0,
			TYPED_BYTE, lcdns_pkg::RS_INSTR, 8'hD0, lcdns_pkg::WC_CMD));
		directed.push_back(dir_entry(lcdns_pkg::CMD_CURSOR, 8'hFF, 8'hFF, 8'h03, 3'd7,
			FROM_MODEL, lcdns_pkg::RS_INSTR, 8'h00, lcdns_pkg::WC_NONE));
		directed.push_back(dir_entry(lcdns_pkg::CMD_CURSOR, 8'h00, 8'h3F, 8'h01, 3'd0,
			FROM_MODEL, lcdns_pkg::RS_INSTR, 8'h00, lcdns_pkg::WC_NONE));
		directed.push_back(dir_entry(lcdns_pkg::CMD_CURSOR, 8'h00, 8'h00, 8'h04, 3'd0,
			TYPED_NONE, lcdns_pkg::RS_INSTR, 8'h00, lcdns_pkg::WC_NONE));
		directed.push_back(dir_entry(lcdns_pkg::CMD_CURSOR, 8'hFF, 8'hFF, 8'hFF, 3'd7,
			TYPED_NONE, lcdns_pkg::RS_INSTR, 8'h00, lcdns_pkg::WC_NONE));
		directed.push_back(dir_entry(lcdns_pkg::CMD_GLYPH, 8'h00, 8'h00, 8'h00, 3'd0,
			TYPED_BYTE, lcdns_pkg::RS_INSTR, lcdns_pkg::OP_SET_CG, lcdns_pkg::WC_CMD));
		directed.push_back(dir_entry(lcdns_pkg::CMD_GLYPH, 8'hFF, 8'hFF, 8'hFF, 3'd7,
			TYPED_BYTE, lcdns_pkg::RS_INSTR, 8'h78, lcdns_pkg::WC_CMD));
		directed.push_back(dir_entry(lcdns_pkg::CMD_NONE, 8'hFF, 8'hFF, 8'h02, 3'd7,
			TYPED_NONE, lcdns_pkg::RS_INSTR, 8'h00, lcdns_pkg::WC_NONE));
		directed.push_back(dir_entry(lcdns_pkg::CMD_WRCMD, 8'h5A, 8'hFF, 8'hFF, 3'd7,
			FROM_MODEL, lcdns_pkg::RS_INSTR, 8'h00, lcdns_pkg::WC_NONE));
		directed.push_back(dir_entry(lcdns_pkg::CMD_INIT, 8'hFF, 8'hFF, 8'hFF, 3'd7,
			FROM_MODEL, lcdns_pkg::RS_INSTR, 8'h00, lcdns_pkg::WC_NONE));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_request(directed[i]);

		// Random phases, each with an idling mix; all but the first load their own row bases.
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_settled();
			if (phase != 0)
				load_line_bases(phase);
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 63; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 63; end
				default: begin send_idle_pct = 6; stall_pct = 6; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Let the sequencer run dry once in the middle of a phase.
				if (phase == 3 && n == ITEMS_PER_PHASE / 2)
					wait_for_steps();
				send_request(random_request());
			end
		end

		wait_settled();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
